@@ hdl/lwqd_pkg.sv @@
package lwqd_pkg;

  localparam int WIN_W     = 4;
  localparam int SERVICE_W = 8;
  localparam int CHOSEN_W  = 3;
  localparam int MASK_W    = 8;

  localparam logic [WIN_W-1:0] WIN_RESET = 4'd8;

endpackage

@@ hdl/lwqd_in_if.sv @@
interface lwqd_in_if;
  import lwqd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [SERVICE_W-1:0] service_time;

  modport source (output valid, output func, output service_time, input ready);
  modport sink (input valid, input func, input service_time, output ready);

endinterface

@@ hdl/lwqd_out_if.sv @@
interface lwqd_out_if;
  import lwqd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHOSEN_W-1:0] chosen_queue;
  logic                accepted;
  logic [MASK_W-1:0]   completed_mask;
  logic [MASK_W-1:0]   busy_mask;

  modport source (
    output valid, output chosen_queue, output accepted,
    output completed_mask, output busy_mask, input ready
  );
  modport sink (
    input valid, input chosen_queue, input accepted,
    input completed_mask, input busy_mask, output ready
  );

endinterface

@@ hdl/lwqd_ram.sv @@
module lwqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/least_work_queue_dispatcher_top.sv @@
// Least-work-left dispatcher over NUM_QUEUES service queues.
// Each transaction on the item channel is one time tick; when func is set it
// also brings a job of service_time ticks. The job goes to the active queue
// with the least remaining work (lowest index on a tie) and is dropped with
// accepted low if that queue already holds QUEUE_DEPTH jobs. Then every
// nonempty active queue spends one tick on its head job and retires it when
// it reaches zero. One result transaction per item appears on the result
// channel, registered, in the cycle after the item is taken.
// Throughput is one item per cycle unless the result channel stalls: the
// minimum search, enqueue and per-queue tick are combinational, and each
// queue owns a small RAM with a prefetched head, to retire a job every tick.
// The result register holds a finished transaction while the receiver
// stalls; a new item is taken in the same cycle the held result drains, and
// none while it stays stalled.
// cfg_we writes windows_in_use, the number of queues taking part. Write it
// only while the block is idle. Reset sets it to 8, empties all queues and
// needs no clearing pass; job storage is only read where a job was written.
module least_work_queue_dispatcher_top #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lwqd_pkg::WIN_W-1:0]   cfg_wdata,
  lwqd_in_if.sink                      item,
  lwqd_out_if.source                   result
);
  import lwqd_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WORK_W = $clog2(255 * QUEUE_DEPTH + 1);

  logic [WIN_W-1:0]     windows_in_use;
  logic [PTR_W-1:0]     head_pointer      [NUM_QUEUES];
  logic [PTR_W-1:0]     head_pointer_next [NUM_QUEUES];
  logic [CNT_W-1:0]     job_count         [NUM_QUEUES];
  logic [CNT_W-1:0]     job_count_next    [NUM_QUEUES];
  logic [WORK_W-1:0]    work_left         [NUM_QUEUES];
  logic [WORK_W-1:0]    work_left_next    [NUM_QUEUES];
  logic [SERVICE_W-1:0] head_time         [NUM_QUEUES];
  logic [SERVICE_W-1:0] head_time_next    [NUM_QUEUES];
  logic [SERVICE_W-1:0] head_cur          [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] head_load, head_load_next;
  logic [NUM_QUEUES-1:0] byp, byp_next;
  logic [SERVICE_W-1:0] byp_data;

  logic [SERVICE_W-1:0] ram_rdata [NUM_QUEUES];
  logic [PTR_W-1:0]     ram_waddr [NUM_QUEUES];
  logic [PTR_W-1:0]     head_inc  [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] ram_we;

  logic                  take;
  logic [SERVICE_W-1:0]  st_eff;
  logic [NUM_QUEUES-1:0] active, win_oh, full, done;
  logic [CHOSEN_W-1:0]   chosen_enc;
  logic                  acc;
  logic [MASK_W-1:0]     done_mask, busy_mask;

  logic                  out_valid;
  logic [CHOSEN_W-1:0]   out_chosen;
  logic                  out_acc;
  logic [MASK_W-1:0]     out_done, out_busy;

  assign take       = item.valid && item.ready;
  assign item.ready = !out_valid || result.ready;
  assign st_eff     = (item.service_time == '0) ? SERVICE_W'(1) : item.service_time;

  // Current head time: a freshly promoted head comes from the RAM, or from
  // the bypass when it was written in the same cycle it was read.
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (head_load[q]) begin
        head_cur[q] = byp[q] ? byp_data : ram_rdata[q];
      end else begin
        head_cur[q] = head_time[q];
      end
    end
  end

  // Tail slot and next head slot of each queue, wrapped at QUEUE_DEPTH.
  always_comb begin
    logic [PTR_W:0] sum;
    logic [PTR_W:0] inc;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      sum = (PTR_W+1)'(head_pointer[q]) + (PTR_W+1)'(job_count[q]);
      if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
        sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
      end
      ram_waddr[q] = PTR_W'(sum);
      inc = (PTR_W+1)'(head_pointer[q]) + (PTR_W+1)'(1);
      if (inc == (PTR_W+1)'(QUEUE_DEPTH)) begin
        inc = '0;
      end
      head_inc[q] = PTR_W'(inc);
    end
  end

  // A queue wins when it beats every lower active queue strictly and no
  // higher active queue beats it; exactly one active queue wins.
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      active[q] = (q == 0) || (q < int'(windows_in_use));
      full[q]   = (job_count[q] == CNT_W'(QUEUE_DEPTH));
    end
    for (int q = 0; q < NUM_QUEUES; q++) begin
      win_oh[q] = active[q];
      for (int p = 0; p < NUM_QUEUES; p++) begin
        if (p < q && active[p] && !(work_left[q] < work_left[p])) begin
          win_oh[q] = 1'b0;
        end
        if (p > q && active[p] && (work_left[p] < work_left[q])) begin
          win_oh[q] = 1'b0;
        end
      end
    end
    chosen_enc = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (win_oh[q] && item.func) begin
        chosen_enc = chosen_enc | CHOSEN_W'(q);
      end
    end
    acc = item.func && ((win_oh & ~full) != '0);
  end

  always_comb begin
    logic                 arr;
    logic [CNT_W-1:0]     cnt_a;
    logic [WORK_W-1:0]    work_a;
    logic [SERVICE_W-1:0] hv;
    logic [SERVICE_W-1:0] t;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      head_pointer_next[q] = head_pointer[q];
      job_count_next[q]    = job_count[q];
      work_left_next[q]    = work_left[q];
      head_time_next[q]    = head_cur[q];
      head_load_next[q]    = 1'b0;
      ram_we[q]            = 1'b0;
      done[q]              = 1'b0;
      arr    = item.func && win_oh[q] && !full[q];
      cnt_a  = job_count[q] + CNT_W'(arr);
      work_a = work_left[q] + (arr ? WORK_W'(st_eff) : '0);
      hv     = (job_count[q] == '0) ? st_eff : head_cur[q];
      t      = (hv != '0) ? hv - SERVICE_W'(1) : hv;
      if (take && active[q]) begin
        ram_we[q] = arr;
        if (cnt_a != '0) begin
          head_time_next[q] = t;
          work_left_next[q] = (work_a != '0) ? work_a - WORK_W'(1) : work_a;
          if (t == '0) begin
            head_pointer_next[q] = head_inc[q];
            job_count_next[q]    = cnt_a - CNT_W'(1);
            head_load_next[q]    = 1'b1;
            done[q]              = 1'b1;
          end else begin
            job_count_next[q] = cnt_a;
          end
        end
      end
      byp_next[q] = ram_we[q] && (ram_waddr[q] == head_pointer_next[q]);
    end
  end

  always_comb begin
    done_mask = '0;
    busy_mask = '0;
    for (int q = 0; q < NUM_QUEUES && q < MASK_W; q++) begin
      done_mask[q] = done[q];
      busy_mask[q] = (job_count_next[q] != '0);
    end
  end

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
    lwqd_ram #(
      .WIDTH (SERVICE_W),
      .DEPTH (QUEUE_DEPTH)
    ) u_store (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr[g]),
      .wdata (st_eff),
      .raddr (head_pointer_next[g]),
      .rdata (ram_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      windows_in_use <= WIN_RESET;
    end else if (cfg_we) begin
      windows_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      head_time[q] <= head_time_next[q];
    end
    byp_data <= st_eff;
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_pointer[q] <= '0;
        job_count[q]    <= '0;
        work_left[q]    <= '0;
      end
      head_load <= '0;
      byp       <= '0;
    end else begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_pointer[q] <= head_pointer_next[q];
        job_count[q]    <= job_count_next[q];
        work_left[q]    <= work_left_next[q];
      end
      head_load <= head_load_next;
      byp       <= byp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_chosen <= chosen_enc;
      out_acc    <= acc;
      out_done   <= done_mask;
      out_busy   <= busy_mask;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid          = out_valid;
  assign result.chosen_queue   = out_chosen;
  assign result.accepted       = out_acc;
  assign result.completed_mask = out_done;
  assign result.busy_mask      = out_busy;

  a_one_winner: assert property (@(posedge clk) disable iff (rst) $onehot(win_oh))
    else $error("dispatch did not select exactly one queue");

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_check
    a_work_matches_count: assert property (@(posedge clk) disable iff (rst)
      (job_count[g] == '0) == (work_left[g] == '0))
      else $error("queue workload sum disagrees with its job count");
    a_count_bound: assert property (@(posedge clk) disable iff (rst)
      job_count[g] <= CNT_W'(QUEUE_DEPTH))
      else $error("queue job count exceeds its depth");
  end

endmodule

@@ bench/least_work_queue_dispatcher_top_tb.sv @@
module least_work_queue_dispatcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lwqd_pkg::*;

  localparam int NQ    = 8;
  localparam int DEPTH = 16;
  localparam int PHASES = 12;
  localparam int PHASE_TICKS = 110;
  localparam int LONG_HOLD = 120;

  typedef struct packed {
    logic                 func;
    logic [SERVICE_W-1:0] service;
  } tick_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic                accepted;
    logic [MASK_W-1:0]   done;
    logic [MASK_W-1:0]   busy;
  } tick_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;

  lwqd_in_if  item_if ();
  lwqd_out_if result_if ();

  least_work_queue_dispatcher_top #(
    .NUM_QUEUES  (NQ),
    .QUEUE_DEPTH (DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_if),
    .result    (result_if)
  );

  always #1 clk = ~clk;

  // Queue state as the block should hold it.
  logic [SERVICE_W-1:0] job_left [NQ][DEPTH];
  int unsigned          head_slot [NQ];
  int unsigned          jobs_held [NQ];
  int unsigned          work_sum [NQ];
  logic [WIN_W-1:0]     windows_model;

  tick_t        ticks_to_send [$];
  tick_result_t due_results [$];

  int  mismatches = 0;
  int  send_gap_max = 0;
  int  recv_gap_max = 0;
  int  send_wait;
  int  recv_wait;
  bit  hold_next = 1'b0;

  function automatic tick_result_t dispatch_tick(input logic func,
                                                 input logic [SERVICE_W-1:0] svc_in);
    tick_result_t         r;
    int                   n;
    int                   pick;
    int                   slot;
    logic [SERVICE_W-1:0] svc;
    logic [SERVICE_W-1:0] t;
    n = (windows_model == 0) ? 1 : ((windows_model > NQ) ? NQ : int'(windows_model));
    r = '0;
    pick = 0;
    if (func) begin
      for (int q = 1; q < n; q++) begin
        if (work_sum[q] < work_sum[pick]) pick = q;
      end
      svc = (svc_in == '0) ? SERVICE_W'(1) : svc_in;
      if (jobs_held[pick] < DEPTH) begin
        slot = (head_slot[pick] + jobs_held[pick]) % DEPTH;
        job_left[pick][slot] = svc;
        jobs_held[pick]++;
        work_sum[pick] += 32'(svc);
        r.accepted = 1'b1;
      end
      r.chosen = pick[CHOSEN_W-1:0];
    end
    for (int q = 0; q < n; q++) begin
      if (jobs_held[q] != 0) begin
        t = job_left[q][head_slot[q]];
        if (t != '0) t = t - SERVICE_W'(1);
        job_left[q][head_slot[q]] = t;
        if (work_sum[q] != 0) work_sum[q]--;
        if (t == '0) begin
          head_slot[q] = (head_slot[q] + 1) % DEPTH;
          jobs_held[q]--;
          if (q < MASK_W) r.done[q] = 1'b1;
        end
      end
    end
    for (int q = 0; q < NQ && q < MASK_W; q++) begin
      if (jobs_held[q] != 0) r.busy[q] = 1'b1;
    end
    return r;
  endfunction

  // Sender: offers queued ticks, random gap after each transaction.
  always @(posedge clk) begin : drive_ticks
    logic  offer;
    tick_t nxt;
    if (rst) begin
      item_if.valid <= 1'b0;
      send_wait = 0;
    end else begin
      offer = item_if.valid;
      if (item_if.valid && item_if.ready) begin
        due_results.push_back(dispatch_tick(item_if.func, item_if.service_time));
        offer = 1'b0;
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (!offer) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (ticks_to_send.size() != 0) begin
          nxt = ticks_to_send.pop_front();
          item_if.func <= nxt.func;
          item_if.service_time <= nxt.service;
          offer = 1'b1;
        end
      end
      item_if.valid <= offer;
    end
  end

  task automatic compare_field(input string what, input logic [MASK_W-1:0] want,
                               input logic [MASK_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%02h, got 0x%02h", $time, what, want, got);
    end
  endtask

  // Receiver: checks every result transaction and stalls at random.
  always @(posedge clk) begin : collect_results
    tick_result_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with none expected, got chosen %0d accepted %0d",
                   $time, result_if.chosen_queue, result_if.accepted);
        end else begin
          want = due_results.pop_front();
          compare_field("chosen_queue", MASK_W'(want.chosen), MASK_W'(result_if.chosen_queue));
          compare_field("accepted", MASK_W'(want.accepted), MASK_W'(result_if.accepted));
          compare_field("completed_mask", want.done, result_if.completed_mask);
          compare_field("busy_mask", want.busy, result_if.busy_mask);
        end
        recv_wait = $urandom_range(0, recv_gap_max);
        // One long hold-off so the result register backs up into the input.
        if (hold_next) begin
          recv_wait = LONG_HOLD;
          hold_next = 1'b0;
        end
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      result_if.ready <= (recv_wait == 0);
    end
  end

  task automatic queue_tick(input logic func, input logic [SERVICE_W-1:0] svc);
    tick_t tk;
    tk.func = func;
    tk.service = svc;
    ticks_to_send.push_back(tk);
  endtask

  // Waits until every tick is sent and every result has come back.
  task automatic drain_all();
    do @(negedge clk);
    while (ticks_to_send.size() != 0 || item_if.valid === 1'b1 || due_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_windows(input logic [WIN_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    windows_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int                   phase_cfg [PHASES];
    int                   arrive_pct;
    logic [SERVICE_W-1:0] svc;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_if.valid = 1'b0;
    item_if.func = 1'b0;
    item_if.service_time = '0;
    result_if.ready = 1'b0;
    windows_model = WIN_RESET;
    for (int q = 0; q < NQ; q++) begin
      head_slot[q] = 0;
      jobs_held[q] = 0;
      work_sum[q] = 0;
      for (int s = 0; s < DEPTH; s++) job_left[q][s] = '0;
    end
    phase_cfg = '{3, 0, 15, 8, 5, 1, 2, 12, 7, 4, 6, 9};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: a bare tick, a zero service time that finishes at once,
    // the longest job, ties on empty queues, alternating bit patterns.
    @(negedge clk);
    queue_tick(1'b0, 8'h00);
    queue_tick(1'b1, 8'h00);
    queue_tick(1'b1, 8'hFF);
    queue_tick(1'b1, 8'h01);
    queue_tick(1'b1, 8'hAA);
    queue_tick(1'b0, 8'h55);
    drain_all();

    // A single queue flooded with long jobs until arrivals are dropped.
    write_windows(4'd1);
    @(negedge clk);
    for (int i = 0; i < 18; i++) queue_tick(1'b1, 8'hFF);
    drain_all();

    for (int p = 0; p < PHASES; p++) begin
      write_windows(phase_cfg[p][WIN_W-1:0]);
      @(negedge clk);
      case (p % 3)
        0: send_gap_max = 0;
        1: send_gap_max = 15;
        default: send_gap_max = 3;
      endcase
      case ((p + 1) % 3)
        0: recv_gap_max = 0;
        1: recv_gap_max = 15;
        default: recv_gap_max = 2;
      endcase
      if (p == 3) begin
        send_gap_max = 0;
        hold_next = 1'b1;
      end
      arrive_pct = $urandom_range(25, 100);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        case ($urandom_range(0, 7))
          0: svc = 8'h00;
          1: svc = 8'hFF;
          2, 3: svc = SERVICE_W'($urandom_range(1, 6));
          default: svc = (p % 2) ? SERVICE_W'($urandom_range(1, 40))
                                 : SERVICE_W'($urandom_range(0, 255));
        endcase
        queue_tick($urandom_range(1, 100) <= arrive_pct, svc);
      end
      drain_all();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
